>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Types, codes and defaults for the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int DEF_NUM_PARTS = 64;
    localparam int DEF_SIZE_BITS = 16;

    localparam int TYPE_W = 2;
    localparam int ID_W   = 7;
    localparam int REQ_SIZE_W = 16;
    localparam int STATUS_W = 2;

    // Request type codes.
    localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]     req_type;
        logic [ID_W-1:0]       block_id;
        logic [REQ_SIZE_W-1:0] req_size;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     granted_id;
    } rsp_t;

    // Command broadcast from the controller to every cell.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FREE,
        CMD_GRANT
    } cell_op_t;

    // Control flags of the scan token that travels down the chain.
    typedef struct packed {
        logic valid;
        logic found;
    } scan_flags_t;

endpackage

>>> rtl/bfpa_cell.sv
// ----------------------------------------------------------------------------
// bfpa_cell
// One partition: its size and busy flag, plus one stage of the best-fit scan.
// ----------------------------------------------------------------------------
module bfpa_cell #(
    parameter int SIZE_BITS = bfpa_pkg::DEF_SIZE_BITS,
    parameter int IDX_W     = 6,
    parameter int IDX       = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfpa_pkg::cell_op_t    cmd_op,
    input  logic [IDX_W-1:0]      cmd_slot,
    input  logic [SIZE_BITS-1:0]  cmd_size,
    input  logic [SIZE_BITS-1:0]  want,
    input  bfpa_pkg::scan_flags_t tok_in,
    input  logic [SIZE_BITS-1:0]  slack_in,
    input  logic [IDX_W-1:0]      slot_in,
    output bfpa_pkg::scan_flags_t tok_out,
    output logic [SIZE_BITS-1:0]  slack_out,
    output logic [IDX_W-1:0]      slot_out
);
    import bfpa_pkg::*;

    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 busy_reg, busy_next;
    scan_flags_t          tok_reg, tok_next;
    logic [SIZE_BITS-1:0] slack_reg, slack_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;

    logic                 sel;
    logic                 fits;
    logic                 take;
    logic [SIZE_BITS-1:0] my_slack;

    assign sel      = (cmd_slot == IDX_W'(IDX));
    assign fits     = !busy_reg && (size_reg >= want);
    assign my_slack = size_reg - want;
    // A strict compare keeps the earlier, lower-numbered candidate on a tie.
    assign take     = tok_in.valid && fits && (!tok_in.found || (my_slack < slack_in));

    always_comb
    begin
        size_next = size_reg;
        busy_next = busy_reg;
        unique case (cmd_op)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                if (sel)
                begin
                    size_next = cmd_size;
                end
            end
            CMD_FREE:
            begin
                if (sel)
                begin
                    busy_next = 1'b0;
                end
            end
            CMD_GRANT:
            begin
                if (sel)
                begin
                    busy_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || take;
        slack_next     = take ? my_slack : slack_in;
        slot_next      = take ? IDX_W'(IDX) : slot_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            busy_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            size_reg <= size_next;
            busy_reg <= busy_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slack_reg <= slack_next;
        slot_reg  <= slot_next;
    end

    assign tok_out   = tok_reg;
    assign slack_out = slack_reg;
    assign slot_out  = slot_reg;

endmodule

>>> rtl/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Fixed-partition table with load, best-fit allocate and free requests.
// ----------------------------------------------------------------------------
// A request is taken on req when start is high and busy is low. Every request
// gives exactly one response on rsp, marked by a one-cycle done strobe; the
// receiver must take it in that cycle.
// Load and free requests, and unknown-type requests, whatever their partition
// number, pass through the execute state and raise done on return to idle.
// Allocate requests ignore the partition number: a scan token walks the row of
// partition cells, one cell per cycle, keeping the best candidate so far, and
// the winner is marked busy when the token leaves the last cell.
// busy is high from acceptance until done, so requests are handled one at a
// time. Reset clears all sizes and busy flags at once and returns the
// controller to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_partition_allocator #(
    parameter int NUM_PARTS = bfpa_pkg::DEF_NUM_PARTS,
    parameter int SIZE_BITS = bfpa_pkg::DEF_SIZE_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bfpa_pkg::req_t req,
    output logic           done,
    output bfpa_pkg::rsp_t rsp
);
    import bfpa_pkg::*;

    localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int CW    = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic [TYPE_W-1:0]    kind_reg, kind_next;
    logic                 id_ok_reg, id_ok_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [SIZE_BITS-1:0] want_reg, want_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [CW-1:0]        id_wide;
    logic [CW-1:0]        grant_wide;

    cell_op_t             cmd_op;
    logic [IDX_W-1:0]     cmd_slot;

    scan_flags_t          tok     [NUM_PARTS+1];
    logic [SIZE_BITS-1:0] tok_slack [NUM_PARTS+1];
    logic [IDX_W-1:0]     tok_slot  [NUM_PARTS+1];

    assign id_wide    = CW'(req.block_id);
    assign grant_wide = CW'(tok_slot[NUM_PARTS]) + CW'(1);

    // Token injected into the first cell in the cycle after an allocate request.
    assign tok[0].valid = (state_reg == S_EXEC) && (kind_reg == REQ_ALLOC);
    assign tok[0].found = 1'b0;
    assign tok_slack[0] = '0;
    assign tok_slot[0]  = '0;

    always_comb
    begin
        cmd_op   = CMD_NONE;
        cmd_slot = slot_reg;
        if ((state_reg == S_EXEC) && id_ok_reg)
        begin
            if (kind_reg == REQ_LOAD)
            begin
                cmd_op = CMD_LOAD;
            end
            else if (kind_reg == REQ_FREE)
            begin
                cmd_op = CMD_FREE;
            end
        end
        else if ((state_reg == S_SCAN) && tok[NUM_PARTS].valid && tok[NUM_PARTS].found)
        begin
            cmd_op   = CMD_GRANT;
            cmd_slot = tok_slot[NUM_PARTS];
        end
    end

    generate
        for (genvar i = 0; i < NUM_PARTS; i++)
        begin : g_cell
            bfpa_cell #(
                .SIZE_BITS (SIZE_BITS),
                .IDX_W     (IDX_W),
                .IDX       (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd_op    (cmd_op),
                .cmd_slot  (cmd_slot),
                .cmd_size  (want_reg),
                .want      (want_reg),
                .tok_in    (tok[i]),
                .slack_in  (tok_slack[i]),
                .slot_in   (tok_slot[i]),
                .tok_out   (tok[i+1]),
                .slack_out (tok_slack[i+1]),
                .slot_out  (tok_slot[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        id_ok_next = id_ok_reg;
        slot_next  = slot_reg;
        id_next    = id_reg;
        want_next  = want_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req.req_type;
                    id_ok_next = (id_wide != '0) && (id_wide <= CW'(NUM_PARTS));
                    slot_next  = IDX_W'(id_wide - CW'(1));
                    id_next    = req.block_id;
                    want_next  = SIZE_BITS'(req.req_size);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (kind_reg == REQ_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (id_ok_reg && ((kind_reg == REQ_LOAD) || (kind_reg == REQ_FREE)))
                    begin
                        rsp_next.status     = ST_OK;
                        rsp_next.granted_id = id_reg;
                    end
                    else
                    begin
                        rsp_next.status     = ST_NOTFOUND;
                        rsp_next.granted_id = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (tok[NUM_PARTS].valid)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (tok[NUM_PARTS].found)
                    begin
                        rsp_next.status     = ST_OK;
                        rsp_next.granted_id = grant_wide[ID_W-1:0];
                    end
                    else
                    begin
                        rsp_next.status     = ST_NOFIT;
                        rsp_next.granted_id = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            kind_reg  <= REQ_LOAD;
            id_ok_reg <= 1'b0;
            slot_reg  <= '0;
            id_reg    <= '0;
            want_reg  <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            kind_reg  <= kind_next;
            id_ok_reg <= id_ok_next;
            slot_reg  <= slot_next;
            id_reg    <= id_next;
            want_reg  <= want_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_SAME(a_fail_id_zero, done && (rsp.status != ST_OK), rsp.granted_id == '0)
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASSERT_NEXT(a_done_pulse, done, !done)
    `ASSERT_SAME(a_token_in_scan, tok[NUM_PARTS].valid, state_reg == S_SCAN)

endmodule

>>> verif/tb_best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// tb_best_fit_partition_allocator
// Self-checking bench for the best-fit partition allocator. Requests are sent
// with random pauses, a local copy of the partition table predicts each
// response, and every done strobe is checked in order against the prediction.
// ----------------------------------------------------------------------------
module tb_best_fit_partition_allocator;

    import bfpa_pkg::*;

    localparam int NUM_PARTS = DEF_NUM_PARTS;
    // Allocate scans the whole table, so this bounds the latency of any request.
    localparam int SCAN_CYCLES = NUM_PARTS + 2;
    // The request type that the block does not know.
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Local copy of the partition table.
    logic [DEF_SIZE_BITS-1:0] tbl_size [NUM_PARTS];
    logic                     tbl_taken [NUM_PARTS];

    rsp_t pending_rsp [$];

    int errors = 0;
    int n_load = 0;
    int n_alloc = 0;
    int n_free = 0;
    int n_other = 0;
    int n_nofit = 0;
    int n_notfound = 0;
    bit no_gaps = 0;

    best_fit_partition_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("Timeout at %0t with %0d responses outstanding", $time, pending_rsp.size());
        $display("tb_best_fit_partition_allocator failed");
        $finish;
    end

    // Applies one request to the local table and returns the response it must give.
    function automatic rsp_t predict_response(req_t r);
        rsp_t res;
        int best;
        logic [DEF_SIZE_BITS-1:0] best_slack;
        best = -1;
        best_slack = '0;
        res.status = ST_NOTFOUND;
        res.granted_id = '0;
        if (r.req_type == REQ_LOAD || r.req_type == REQ_FREE)
        begin
            if (r.block_id != 0 && r.block_id <= NUM_PARTS)
            begin
                if (r.req_type == REQ_LOAD)
                    tbl_size[r.block_id - 1] = r.req_size;
                else
                    tbl_taken[r.block_id - 1] = 1'b0;
                res.status = ST_OK;
                res.granted_id = r.block_id;
            end
        end
        else if (r.req_type == REQ_ALLOC)
        begin
            for (int i = 0; i < NUM_PARTS; i++)
            begin
                if (!tbl_taken[i] && tbl_size[i] >= r.req_size)
                begin
                    // Strictly smaller slack only, so ties keep the lowest number.
                    if (best < 0 || tbl_size[i] - r.req_size < best_slack)
                    begin
                        best = i;
                        best_slack = tbl_size[i] - r.req_size;
                    end
                end
            end
            if (best >= 0)
            begin
                tbl_taken[best] = 1'b1;
                res.status = ST_OK;
                res.granted_id = ID_W'(best + 1);
            end
            else
            begin
                res.status = ST_NOFIT;
            end
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with no request outstanding, expected none, got status %0d id %0d",
                         $time, rsp.status, rsp.granted_id);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_id !== want.granted_id)
                begin
                    $display("%0t: granted_id mismatch, expected %0d, got %0d",
                             $time, want.granted_id, rsp.granted_id);
                    errors++;
                end
                if (want.status == ST_NOFIT)
                    n_nofit++;
                else if (want.status == ST_NOTFOUND)
                    n_notfound++;
            end
        end
    end

    // Lowers start for a random number of cycles; most pauses are short.
    task automatic sender_pause();
        int r;
        int n;
        if (no_gaps)
            return;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(12, 90);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_request(logic [TYPE_W-1:0] kind, int id, int size);
        req_t item;
        item.req_type = kind;
        item.block_id = id[ID_W-1:0];
        item.req_size = size[REQ_SIZE_W-1:0];
        start <= 1'b1;
        req <= item;
        do @(posedge clk); while (busy);
        pending_rsp.push_back(predict_response(item));
        if (kind == REQ_LOAD)
            n_load++;
        else if (kind == REQ_ALLOC)
            n_alloc++;
        else if (kind == REQ_FREE)
            n_free++;
        else
            n_other++;
        sender_pause();
    endtask

    // Holds the sender off until every outstanding response has arrived.
    task automatic drain_responses();
        start <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
    endtask

    function automatic int pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 86)
            return $urandom_range(1, NUM_PARTS);
        else if (r < 92)
            return 0;
        else
            return $urandom_range(NUM_PARTS + 1, 127);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 65535);
        else if (r < 75)
            return $urandom_range(0, 31);
        else
            return $urandom_range(1, 8) * 256 + $urandom_range(0, 3);
    endfunction

    // Returns the number of a taken partition, or a random one if none is taken.
    function automatic int pick_taken_id();
        int ids [$];
        for (int i = 0; i < NUM_PARTS; i++)
            if (tbl_taken[i])
                ids.push_back(i + 1);
        if (ids.size() == 0)
            return $urandom_range(1, NUM_PARTS);
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    task automatic test_directed();
        // An empty table holds only size-zero partitions.
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_LOAD, 0, 65535);
        send_request(REQ_LOAD, NUM_PARTS + 1, 5);
        send_request(REQ_FREE, 127, 0);
        send_request(REQ_UNKNOWN, 1, 65535);
        send_request(REQ_UNKNOWN, 127, 0);
        send_request(REQ_LOAD, NUM_PARTS, 65535);
        // Partition 1 is taken; reloading it must keep it taken.
        send_request(REQ_LOAD, 1, 300);
        send_request(REQ_LOAD, 2, 100);
        send_request(REQ_LOAD, 3, 100);
        send_request(REQ_LOAD, 4, 120);
        send_request(REQ_ALLOC, 0, 100);
        send_request(REQ_ALLOC, 0, 100);
        send_request(REQ_ALLOC, 0, 100);
        send_request(REQ_ALLOC, 127, 65535);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_FREE, 3, 65535);
        send_request(REQ_FREE, 3, 0);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_FREE, 1, 0);
        send_request(REQ_ALLOC, 127, 200);
        send_request(REQ_ALLOC, 64, 16'h5555);
        send_request(REQ_FREE, NUM_PARTS, 16'hAAAA);
        drain_responses();
    endtask

    task automatic test_random_mix(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_request(REQ_LOAD, pick_id(), pick_size());
            else if (r < 72)
                send_request(REQ_ALLOC, pick_id(), pick_size());
            else if (r < 95)
                send_request(REQ_FREE, pick_id(), pick_size());
            else
                send_request(REQ_UNKNOWN, pick_id(), pick_size());
            if ($urandom_range(0, 199) == 0)
                drain_responses();
        end
        drain_responses();
    endtask

    // Rounds of loads followed by allocations, frees and reloads of a small size
    // set, so exact fits, ties and running out of room all come up often.
    task automatic test_pool_churn(int rounds);
        int r;
        for (int k = 0; k < rounds; k++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 12))
                send_request(REQ_LOAD, $urandom_range(1, NUM_PARTS),
                             $urandom_range(0, 8) * 16);
            repeat ($urandom_range(12, 24))
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_request(REQ_ALLOC, $urandom_range(0, 127),
                                 $urandom_range(0, 8) * 16 - $urandom_range(0, 2));
                else if (r < 90)
                    send_request(REQ_FREE, pick_taken_id(), $urandom_range(0, 65535));
                else if (r < 97)
                    send_request(REQ_LOAD, pick_taken_id(), $urandom_range(0, 8) * 16);
                else
                    send_request(REQ_FREE, pick_id(), 0);
            end
        end
        no_gaps = 0;
        drain_responses();
    endtask

    // Fills the whole table, allocates past exhaustion, then frees everything.
    task automatic test_exhaust();
        no_gaps = 1;
        for (int id = 1; id <= NUM_PARTS; id++)
            send_request(REQ_LOAD, id, $urandom_range(0, 65535));
        no_gaps = 0;
        repeat (NUM_PARTS + 6)
            send_request(REQ_ALLOC, $urandom_range(0, 127), $urandom_range(0, 40000));
        drain_responses();
        for (int id = NUM_PARTS; id >= 1; id--)
            send_request(REQ_FREE, id, 0);
        for (int id = 1; id <= NUM_PARTS; id++)
            send_request(REQ_LOAD, id, 16'hFFFF);
        repeat (8)
            send_request(REQ_ALLOC, 0, 16'hFFFF);
        drain_responses();
    endtask

    initial
    begin
        int waited;
        waited = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        for (int i = 0; i < NUM_PARTS; i++)
        begin
            tbl_size[i] = '0;
            tbl_taken[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(350);
        test_pool_churn(34);
        test_exhaust();
        test_random_mix(120);

        start <= 1'b0;
        while (pending_rsp.size() != 0 && waited < 4 * SCAN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SCAN_CYCLES + 8) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("%0t: %0d responses never arrived, expected 0 outstanding, got %0d",
                     $time, pending_rsp.size(), pending_rsp.size());
            errors += pending_rsp.size();
        end

        $display("Sent %0d loads, %0d allocations, %0d frees and %0d unknown-type requests.",
                 n_load, n_alloc, n_free, n_other);
        $display("Saw %0d no-fit and %0d not-found responses; %0d check failures.",
                 n_nofit, n_notfound, errors);
        if (errors == 0)
            $display("tb_best_fit_partition_allocator passed");
        else
            $display("tb_best_fit_partition_allocator failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/bfpa_pkg.sv
rtl/bfpa_cell.sv
rtl/best_fit_partition_allocator.sv
verif/tb_best_fit_partition_allocator.sv
